// ===== rtl/core/psps_pkg.sv =====
// Shared types and constants for the phase-shift PWM sequencer.
// Holds the sequencer states, mode and register codes, the config bundle
// and the shared multiplier operand bundle. No dependencies.
package psps_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_SAMPLE,
    S_ROUND,
    S_WRAP,
    S_SCALE,
    S_RECIP,
    S_BACK,
    S_FIX,
    S_HOLD
  } state_t;

  typedef enum logic [1:0] {
    MODE_FIXED,
    MODE_EXTERNAL,
    MODE_TIMED,
    MODE_TRIGGERED
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE,
    REG_SOFT_PAUSE,
    REG_FIXED_PHASE,
    REG_STEP_DELTA,
    REG_STEP_INTERVAL_MS,
    REG_SWEEP_STEPS,
    REG_CLOCKS_PER_TOGGLE
  } reg_idx_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] CLOCKS_PER_TOGGLE_RST = 16'd8000;

  localparam int PHASE_W   = 9;
  localparam int PHASE_ACC_W = 11;
  localparam logic [8:0]  PHASE_HALF = 9'd180;
  localparam logic [10:0] PHASE_FULL = 11'd360;
  localparam logic [7:0]  TRIG_PATTERN = 8'hF0;

  // External mode: round(sample * 360 / 1024), halves up
  localparam logic [22:0] SAMPLE_SCALE = 23'd360;
  localparam logic [18:0] ROUND_BIAS   = 19'd512;

  // Divide by 180 = shift by 2, then divide by 45 through a reciprocal
  localparam int          RECIP_SHIFT = 28;
  localparam logic [22:0] RECIP_45    = 23'd5965232;
  localparam logic [22:0] DIV_45      = 23'd45;

  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 23;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic                 en;
    logic [MUL_A_W-1:0]   a;
    logic [MUL_B_W-1:0]   b;
  } mul_op_t;

  typedef struct packed {
    mode_t              mode;
    logic               soft_pause;
    logic [8:0]         fixed_phase;
    logic signed [9:0]  step_delta;
    logic [14:0]        step_interval_ms;
    logic [14:0]        sweep_steps;
    logic [15:0]        clocks_per_toggle;
    logic               clr_reversed;
    logic               clr_sweep;
  } cfg_t;

endpackage

// ===== rtl/core/psps_cfg.sv =====
// Configuration register file for the phase-shift PWM sequencer.
// Decodes index/data beats into cfg_t fields and side-effect pulses.
// Depends on psps_pkg.
module psps_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [psps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psps_pkg::CFG_DATA_W-1:0]  cfg_data,
  output psps_pkg::cfg_t                   cfg
);
  import psps_pkg::*;

  logic     wr;
  reg_idx_t idx;

  mode_t             mode;
  logic              soft_pause;
  logic [8:0]        fixed_phase;
  logic signed [9:0] step_delta;
  logic [14:0]       step_interval_ms;
  logic [14:0]       sweep_steps;
  logic [15:0]       clocks_per_toggle;

  assign cfg_ready = !rst;
  assign wr        = cfg_valid && cfg_ready;
  assign idx       = reg_idx_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= MODE_FIXED;
      soft_pause        <= 1'b0;
      fixed_phase       <= '0;
      step_delta        <= '0;
      step_interval_ms  <= '0;
      sweep_steps       <= '0;
      clocks_per_toggle <= CLOCKS_PER_TOGGLE_RST;
    end else if (wr) begin
      case (idx)
        REG_MODE: begin
          mode       <= mode_t'(cfg_data[1:0]);
          soft_pause <= 1'b0;
        end
        REG_SOFT_PAUSE:        soft_pause        <= cfg_data[0];
        REG_FIXED_PHASE:       fixed_phase       <= cfg_data[8:0];
        REG_STEP_DELTA:        step_delta        <= $signed(cfg_data[9:0]);
        REG_STEP_INTERVAL_MS:  step_interval_ms  <= cfg_data[14:0];
        REG_SWEEP_STEPS:       sweep_steps       <= cfg_data[14:0];
        REG_CLOCKS_PER_TOGGLE: clocks_per_toggle <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.mode              = mode;
    cfg.soft_pause        = soft_pause;
    cfg.fixed_phase       = fixed_phase;
    cfg.step_delta        = step_delta;
    cfg.step_interval_ms  = step_interval_ms;
    cfg.sweep_steps       = sweep_steps;
    cfg.clocks_per_toggle = clocks_per_toggle;
    cfg.clr_reversed      = wr && (idx == REG_STEP_DELTA);
    cfg.clr_sweep         = wr && (idx == REG_SWEEP_STEPS);
  end

endmodule

// ===== rtl/core/psps_mul.sv =====
// Shared multiplier of the sequencer, product registered.
// Used in turn for sample scaling, compare scaling and reciprocal division.
// Depends on psps_pkg.
module psps_mul (
  input  logic                           clk,
  input  psps_pkg::mul_op_t              op,
  output logic [psps_pkg::MUL_P_W-1:0]   prod
);
  import psps_pkg::*;

  always_ff @(posedge clk) begin
    if (op.en) begin
      prod <= MUL_P_W'(op.a) * MUL_P_W'(op.b);
    end
  end

endmodule

// ===== rtl/core/psps_core.sv =====
// Sequencer and state of the phase-shift PWM sequencer.
// Picks the phase per mode, wraps it, scales the compare value through
// the shared multiplier and holds the result beat. Depends on psps_pkg.
module psps_core (
  input  logic                           clk,
  input  logic                           rst,
  input  psps_pkg::cfg_t                 cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           ms_tick,
  input  logic                           pause_level,
  input  logic                           trigger_level,
  input  logic [9:0]                     analog_phase,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           phase_updated,
  output logic                           keep_polarity,
  output logic [15:0]                    compare_value,
  output logic [8:0]                     phase_now,
  output psps_pkg::mul_op_t              mul_op,
  input  logic [psps_pkg::MUL_P_W-1:0]   prod
);
  import psps_pkg::*;

  state_t state, state_next;

  // captured beat
  logic       tick_q, pause_q, trig_q;
  logic [9:0] sample_q;

  // block state
  logic [8:0]  current_phase;
  logic [15:0] elapsed_ms;
  logic [7:0]  trigger_history;
  logic [15:0] sweep_count;
  logic        delta_reversed;
  logic [15:0] last_compare;
  logic        last_polarity;
  logic        updated_q;

  // working registers
  logic signed [PHASE_ACC_W-1:0] phase_acc;
  logic [21:0] div_y;
  logic [15:0] div_q0;

  // evaluation terms
  logic [15:0] elapsed_inc;
  logic        paused;
  logic [7:0]  hist_shift;
  logic signed [PHASE_ACC_W-1:0] delta;
  logic signed [PHASE_ACC_W-1:0] step_sum;
  logic        do_step;
  logic        apply;
  logic        acc_in_range;
  logic [8:0]  span9;
  logic [21:0] div_rem;
  logic        in_accept;

  assign in_ready  = (state == S_IDLE) && !rst;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    elapsed_inc = (tick_q && (elapsed_ms != 16'hFFFF)) ? elapsed_ms + 16'd1 : elapsed_ms;
    paused      = cfg.soft_pause || pause_q;
    hist_shift  = {trigger_history[6:0], trig_q};
    delta       = delta_reversed ? -PHASE_ACC_W'(cfg.step_delta) : PHASE_ACC_W'(cfg.step_delta);
    step_sum    = $signed({2'b00, current_phase}) + delta;
    do_step     = !paused &&
                  (((cfg.mode == MODE_TIMED) && (elapsed_inc > {1'b0, cfg.step_interval_ms})) ||
                   ((cfg.mode == MODE_TRIGGERED) && (hist_shift == TRIG_PATTERN)));
    apply       = (cfg.mode == MODE_FIXED) || (!paused && (cfg.mode == MODE_EXTERNAL)) || do_step;
    acc_in_range = !phase_acc[PHASE_ACC_W-1] && ($unsigned(phase_acc) < PHASE_FULL);
    // distance to the next half-period boundary, 1..180
    span9       = (current_phase < PHASE_HALF) ? PHASE_HALF - current_phase
                                               : (PHASE_HALF + PHASE_HALF) - current_phase;
    div_rem     = div_y - prod[21:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_accept) state_next = S_EVAL;
      S_EVAL: begin
        if ((cfg.mode == MODE_FIXED) || do_step) begin
          state_next = S_WRAP;
        end else if (!paused && (cfg.mode == MODE_EXTERNAL)) begin
          state_next = S_SAMPLE;
        end else begin
          state_next = S_HOLD;
        end
      end
      S_SAMPLE: state_next = S_ROUND;
      S_ROUND:  state_next = S_WRAP;
      S_WRAP:   if (acc_in_range) state_next = S_SCALE;
      S_SCALE:  state_next = S_RECIP;
      S_RECIP:  state_next = S_BACK;
      S_BACK:   state_next = S_FIX;
      S_FIX:    state_next = S_HOLD;
      S_HOLD:   if (!out_valid || out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_op = '0;
    case (state)
      S_SAMPLE: begin
        mul_op.en = 1'b1;
        mul_op.a  = MUL_A_W'(sample_q);
        mul_op.b  = SAMPLE_SCALE;
      end
      S_SCALE: begin
        mul_op.en = 1'b1;
        mul_op.a  = MUL_A_W'(cfg.clocks_per_toggle);
        mul_op.b  = MUL_B_W'(span9[7:0]);
      end
      S_RECIP: begin
        mul_op.en = 1'b1;
        mul_op.a  = MUL_A_W'(prod[23:2]);
        mul_op.b  = RECIP_45;
      end
      S_BACK: begin
        mul_op.en = 1'b1;
        mul_op.a  = MUL_A_W'(prod[RECIP_SHIFT+15:RECIP_SHIFT]);
        mul_op.b  = DIV_45;
      end
      default: mul_op = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      tick_q   <= ms_tick;
      pause_q  <= pause_level;
      trig_q   <= trigger_level;
      sample_q <= analog_phase;
    end
    case (state)
      S_EVAL: begin
        if (cfg.mode == MODE_FIXED) begin
          phase_acc <= PHASE_ACC_W'(cfg.fixed_phase);
        end else begin
          phase_acc <= step_sum;
        end
      end
      S_ROUND:  phase_acc <= PHASE_ACC_W'((prod[18:0] + ROUND_BIAS) >> 10);
      S_WRAP: begin
        if (phase_acc[PHASE_ACC_W-1]) begin
          phase_acc <= phase_acc + $signed(PHASE_FULL);
        end else if (!acc_in_range) begin
          phase_acc <= phase_acc - $signed(PHASE_FULL);
        end
      end
      S_RECIP:  div_y  <= prod[23:2];
      S_BACK:   div_q0 <= prod[RECIP_SHIFT+15:RECIP_SHIFT];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      current_phase   <= '0;
      elapsed_ms      <= '0;
      trigger_history <= '0;
      sweep_count     <= '0;
      delta_reversed  <= 1'b0;
      last_compare    <= '0;
      last_polarity   <= 1'b1;
      updated_q       <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_EVAL: begin
          elapsed_ms <= apply ? 16'd0 : elapsed_inc;
          updated_q  <= apply;
          if (!paused && (cfg.mode == MODE_TRIGGERED)) begin
            trigger_history <= hist_shift;
          end
          if (do_step && (cfg.sweep_steps != '0)) begin
            if (sweep_count > {1'b0, cfg.sweep_steps}) begin
              sweep_count    <= '0;
              delta_reversed <= !delta_reversed;
            end else begin
              sweep_count <= sweep_count + 16'd1;
            end
          end
        end
        S_WRAP: begin
          if (acc_in_range) begin
            current_phase <= phase_acc[PHASE_W-1:0];
            last_polarity <= phase_acc[PHASE_W-1:0] < PHASE_HALF;
          end
        end
        // reciprocal estimate is low by at most one
        S_FIX: last_compare <= div_q0 + 16'(div_rem >= 22'(DIV_45));
        default: ;
      endcase
      if (cfg.clr_reversed) delta_reversed <= 1'b0;
      if (cfg.clr_sweep)    sweep_count    <= '0;

      if ((state == S_HOLD) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result beat, loaded when the output stage is free
  always_ff @(posedge clk) begin
    if ((state == S_HOLD) && (!out_valid || out_ready)) begin
      phase_updated <= updated_q;
      keep_polarity <= last_polarity;
      compare_value <= last_compare;
      phase_now     <= current_phase;
    end
  end

endmodule

// ===== rtl/core/phase_shift_pwm_sequencer.sv =====
// Phase-shift PWM sequencer: one input beat is one polling pass and gives
// exactly one result beat with the applied phase, its polarity and the
// compare value for the second channel. A pass with no phase applied runs
// accept, evaluate and output load; one that applies a phase runs accept,
// evaluate, one to three wrap steps, three turns of the one shared multiplier
// for the compare scaling and the reciprocal divide by 180, a correction
// step and the output load, plus a sample scaling turn and a rounding step
// in external mode. The multiplier is used for one operation at a time; a
// stalled result beat holds the pass in its output load step. The
// block takes one beat at a time; configuration is written through its own
// index/data channel.
module phase_shift_pwm_sequencer (
  input  logic        clk,
  input  logic        rst,
  // slave: [0] ms_tick, [1] pause_level, [2] trigger_level, [12:3] analog_phase
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  // master: [0] phase_updated, [1] keep_polarity, [17:2] compare_value,
  //         [26:18] phase_now
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [psps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import psps_pkg::*;

  cfg_t               cfg;
  mul_op_t            mul_op;
  logic [MUL_P_W-1:0] prod;

  logic        phase_updated;
  logic        keep_polarity;
  logic [15:0] compare_value;
  logic [8:0]  phase_now;

  psps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  psps_mul u_mul (
    .clk  (clk),
    .op   (mul_op),
    .prod (prod)
  );

  psps_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .ms_tick       (s_axis_tdata[0]),
    .pause_level   (s_axis_tdata[1]),
    .trigger_level (s_axis_tdata[2]),
    .analog_phase  (s_axis_tdata[12:3]),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .phase_updated (phase_updated),
    .keep_polarity (keep_polarity),
    .compare_value (compare_value),
    .phase_now     (phase_now),
    .mul_op        (mul_op),
    .prod          (prod)
  );

  assign m_axis_tdata = {5'b00000, phase_now, compare_value, keep_polarity, phase_updated};

endmodule

// ===== rtl/core/psps_check.sv =====
// Port-level checker for the phase-shift PWM sequencer, bound to the top.
// Watches the stream ports only. Depends on nothing but the top's ports.
module psps_check (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // one pass at a time: drop ready right after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready stayed high after an accepted beat");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[26:18] < 9'd360))
    else $error("phase_now out of 0..359");

  a_polarity_match: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[1] == (m_axis_tdata[26:18] < 9'd180)))
    else $error("keep_polarity disagrees with phase_now");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result beat changed");

endmodule

bind phase_shift_pwm_sequencer psps_check u_psps_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
